FILE: src/hcf_pkg.sv
// Shared types and constants of the Hertzian contact force core.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package hcf_pkg;

  // Square root of a 56-bit radicand: one result bit per step.
  localparam int unsigned SqrtSteps         = 28;
  localparam int unsigned SqrtStepsPerStage = 2;
  localparam int unsigned SqrtStages        = SqrtSteps / SqrtStepsPerStage;

  // Register stages after the square root, up to and including the result register.
  localparam int unsigned TailStages = 13;

  // Edges from item acceptance to the edge that takes its result.
  localparam int unsigned HcfLatency = 1 + SqrtStages + TailStages;

  localparam logic [47:0] ForceMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] ForceMin = 48'h8000_0000_0000;
  localparam logic [46:0] MagMax   = 47'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] separation;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic        [47:0] stiffness;
    logic        [31:0] damping;
    logic               has_second_body;
  } hcf_in_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic        [46:0] normal_magnitude;
    logic               apply_to_second;
  } hcf_out_t;

  // Data that rides alongside the square root pipeline.
  typedef struct packed {
    logic [31:0]       ov;      // overlap, Q8.24
    logic [2:0][31:0]  nrm;     // normal x, y, z (signed Q2.30)
    logic [2:0][64:0]  dv;      // damping * velocity per axis (signed)
    logic [47:0]       stiff;
    logic              second;
  } hcf_side_t;

endpackage

`default_nettype wire

FILE: src/hertz_contact_force_core.sv
// Top level of the Hertzian spring-dashpot contact force core.
// Depends on hcf_pkg and instantiates hcf_sqrt.
`timescale 1ns / 1ps
`default_nettype none

// Computes the normal contact force of one Hertzian spring-dashpot contact per item:
// spring = stiffness * overlap^1.5 with overlap = max(-separation, 0), force on
// the first body = -normal * spring - damping * velocity (Q24.24, saturated), and the
// saturated magnitude of that force's normal component. One item is taken every
// clock cycle; busy stays low. Each result appears on result_o with done_o high for
// exactly one cycle, after one input register, 14 square-root stages at two root
// bits each and 13 stages of multiply, add and saturate, and is taken at the edge
// that ends that cycle. The receiver has no way to hold results off and must take
// every done_o cycle. Results come out in item order. has_second_body passes through
// as apply_to_second: the caller applies the negated force to the second body.

module hertz_contact_force_core import hcf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  hcf_in_t  item_i,
  output logic     done_o,
  output hcf_out_t result_o
);

  typedef struct packed {
    logic [2:0][47:0] frc;
    logic             second;
  } tail_t;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic    accept;
  logic    a_valid_q;
  hcf_in_t a_item_q;

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_item_q <= item_i;
    end
  end

  // Overlap, damping products and the data the square root carries along.
  hcf_side_t          a_side;
  logic signed [31:0] a_vel [3];

  always_comb begin
    a_vel[0] = a_item_q.rel_vel_x;
    a_vel[1] = a_item_q.rel_vel_y;
    a_vel[2] = a_item_q.rel_vel_z;
    // Zero or positive distance: no overlap, no spring term.
    a_side.ov     = a_item_q.separation[31] ? 32'(-a_item_q.separation) : '0;
    a_side.nrm    = {a_item_q.normal_z, a_item_q.normal_y, a_item_q.normal_x};
    a_side.stiff  = a_item_q.stiffness;
    a_side.second = a_item_q.has_second_body;
    for (int i = 0; i < 3; i++) begin
      a_side.dv[i] = $signed({1'b0, a_item_q.damping}) * a_vel[i];
    end
  end

  // ---------------------------------------------------------------------------
  // sqrt(overlap) in Q4.24
  // ---------------------------------------------------------------------------
  logic      sq_valid;
  logic [27:0] sq_root;
  hcf_side_t sq_side;

  hcf_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (a_valid_q),
    .radicand_i ({a_side.ov, 24'b0}),
    .side_i     (a_side),
    .valid_o    (sq_valid),
    .root_o     (sq_root),
    .side_o     (sq_side)
  );

  // ---------------------------------------------------------------------------
  // Tail pipeline registers
  // ---------------------------------------------------------------------------
  logic [TailStages-1:0] pv_q;

  // overlap^1.5
  logic [35:0]        p1_p_q;
  hcf_side_t          p1_side_q;
  // stiffness partial products
  logic [41:0]        p2_hh_q, p2_hl_q, p2_lh_q, p2_ll_q;
  hcf_side_t          p2_side_q;
  // partial sums
  logic [83:0]        p3_a_q;
  logic [48:0]        p3_b_q;
  hcf_side_t          p3_side_q;
  // spring term S
  logic [83:0]        p4_s_q;
  hcf_side_t          p4_side_q;
  // normal times 28-bit chunks of S
  logic signed [60:0] p5_m_q [3][3];
  hcf_side_t          p5_side_q;
  // partial sums per axis
  logic signed [89:0] p6_t1_q [3];
  logic signed [95:0] p6_t0_q [3];
  logic [2:0][31:0]   p6_nrm_q;
  logic               p6_second_q;
  // full sum per axis
  logic signed [117:0] p7_sum_q [3];
  logic [2:0][31:0]   p7_nrm_q;
  logic               p7_second_q;
  // saturated force
  tail_t              p8_tail_q;
  logic [2:0][31:0]   p8_nrm_q;
  // normal times force halves
  logic signed [55:0] p9_dh_q [3];
  logic signed [56:0] p9_dl_q [3];
  tail_t              p9_tail_q;
  // per-axis dot terms
  logic signed [80:0] p10_d_q [3];
  tail_t              p10_tail_q;
  // dot product reduction
  logic signed [82:0] p11_d01_q, p11_d2_q;
  tail_t              p11_tail_q;
  logic signed [82:0] p12_dot_q;
  tail_t              p12_tail_q;
  // result register
  hcf_out_t           result_q;

  // Next values
  logic [59:0]         p1_prod;
  logic [41:0]         p2_hh_d, p2_hl_d, p2_lh_d, p2_ll_d;
  logic [83:0]         p3_a_d;
  logic [48:0]         p3_b_d;
  logic [83:0]         p4_s_d;
  logic signed [60:0]  p5_m_d [3][3];
  logic signed [89:0]  p6_t1_d [3];
  logic signed [95:0]  p6_t0_d [3];
  logic signed [117:0] p7_sum_d [3];
  tail_t               p8_tail_d;
  logic signed [55:0]  p9_dh_d [3];
  logic signed [56:0]  p9_dl_d [3];
  logic signed [80:0]  p10_d_d [3];
  logic signed [82:0]  p11_d01_d, p11_d2_d;
  logic signed [82:0]  p12_dot_d;
  hcf_out_t            result_d;

  always_comb begin
    logic signed [117:0] neg;
    logic [71:0]         quo;
    logic [82:0]         mag;

    // overlap * sqrt(overlap), back to Q12.24
    p1_prod = 60'(sq_side.ov) * 60'(sq_root);

    // stiffness (2 x 24 bits) times P (2 x 18 bits)
    p2_hh_d = p1_side_q.stiff[47:24] * p1_p_q[35:18];
    p2_hl_d = p1_side_q.stiff[47:24] * p1_p_q[17:0];
    p2_lh_d = p1_side_q.stiff[23:0]  * p1_p_q[35:18];
    p2_ll_d = p1_side_q.stiff[23:0]  * p1_p_q[17:0];

    // high-high and low-low do not overlap; cross terms meet at weight 2^18
    p3_a_d = {p2_hh_q, p2_ll_q};
    p3_b_d = {1'b0, p2_hl_q, 6'b0} + 49'(p2_lh_q);

    p4_s_d = p3_a_q + 84'({p3_b_q, 18'b0});

    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        p5_m_d[i][k] = $signed(p4_side_q.nrm[i]) * $signed({1'b0, p4_s_q[28*k +: 28]});
      end
    end

    // sum = n*S + (damping*velocity) << 30, in Q.70
    for (int i = 0; i < 3; i++) begin
      p6_t1_d[i] = (90'(p5_m_q[i][2]) <<< 28) + 90'(p5_m_q[i][1]);
      p6_t0_d[i] = (96'($signed(p5_side_q.dv[i])) <<< 30) + 96'(p5_m_q[i][0]);
      p7_sum_d[i] = (118'(p6_t1_q[i]) <<< 28) + 118'(p6_t0_q[i]);
    end

    // Negate, floor-divide by 2^46, clamp to 48 bits signed.
    neg = '0;
    quo = '0;
    for (int i = 0; i < 3; i++) begin
      neg = -p7_sum_q[i];
      quo = neg[117:46];
      if ((&quo[71:47]) || !(|quo[71:47])) begin
        p8_tail_d.frc[i] = quo[47:0];
      end else begin
        p8_tail_d.frc[i] = quo[71] ? ForceMin : ForceMax;
      end
    end
    p8_tail_d.second = p7_second_q;

    // normal . force with the force split into signed high and unsigned low halves
    for (int i = 0; i < 3; i++) begin
      p9_dh_d[i] = $signed(p8_nrm_q[i]) * $signed(p8_tail_q.frc[i][47:24]);
      p9_dl_d[i] = $signed(p8_nrm_q[i]) * $signed({1'b0, p8_tail_q.frc[i][23:0]});
      p10_d_d[i] = (81'(p9_dh_q[i]) <<< 24) + 81'(p9_dl_q[i]);
    end

    p11_d01_d = 83'(p10_d_q[0]) + 83'(p10_d_q[1]);
    p11_d2_d  = 83'(p10_d_q[2]);
    p12_dot_d = p11_d01_q + p11_d2_q;

    // |dot| >> 30, clamp to 47 bits
    mag = p12_dot_q[82] ? 83'(-p12_dot_q) : 83'(p12_dot_q);
    result_d.force_x          = p12_tail_q.frc[0];
    result_d.force_y          = p12_tail_q.frc[1];
    result_d.force_z          = p12_tail_q.frc[2];
    result_d.normal_magnitude = (|mag[82:77]) ? MagMax : mag[76:30];
    result_d.apply_to_second  = p12_tail_q.second;
  end

  // Valid bits travel with the data; nothing ever stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q <= {pv_q[TailStages-2:0], sq_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    p1_p_q      <= p1_prod[59:24];
    p1_side_q   <= sq_side;

    p2_hh_q     <= p2_hh_d;
    p2_hl_q     <= p2_hl_d;
    p2_lh_q     <= p2_lh_d;
    p2_ll_q     <= p2_ll_d;
    p2_side_q   <= p1_side_q;

    p3_a_q      <= p3_a_d;
    p3_b_q      <= p3_b_d;
    p3_side_q   <= p2_side_q;

    p4_s_q      <= p4_s_d;
    p4_side_q   <= p3_side_q;

    p5_m_q      <= p5_m_d;
    p5_side_q   <= p4_side_q;

    p6_t1_q     <= p6_t1_d;
    p6_t0_q     <= p6_t0_d;
    p6_nrm_q    <= p5_side_q.nrm;
    p6_second_q <= p5_side_q.second;

    p7_sum_q    <= p7_sum_d;
    p7_nrm_q    <= p6_nrm_q;
    p7_second_q <= p6_second_q;

    p8_tail_q   <= p8_tail_d;
    p8_nrm_q    <= p7_nrm_q;

    p9_dh_q     <= p9_dh_d;
    p9_dl_q     <= p9_dl_d;
    p9_tail_q   <= p8_tail_q;

    p10_d_q     <= p10_d_d;
    p10_tail_q  <= p9_tail_q;

    p11_d01_q   <= p11_d01_d;
    p11_d2_q    <= p11_d2_d;
    p11_tail_q  <= p10_tail_q;

    p12_dot_q   <= p12_dot_d;
    p12_tail_q  <= p11_tail_q;

    result_q    <= result_d;
  end

  assign done_o   = pv_q[TailStages-1];
  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: src/hcf_sqrt.sv
// Pipelined integer square root, two result bits per register stage.
// Depends on hcf_pkg for stage counts and the side-data type.
`timescale 1ns / 1ps
`default_nettype none

module hcf_sqrt import hcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  logic [55:0] radicand_i,
  input  hcf_side_t side_i,
  output logic      valid_o,
  output logic [27:0] root_o,
  output hcf_side_t side_o
);

  logic [SqrtStages-1:0] valid_q;
  logic [55:0]           rad_q  [SqrtStages];
  logic [29:0]           rem_q  [SqrtStages];
  logic [27:0]           root_q [SqrtStages];
  hcf_side_t             side_q [SqrtStages];

  logic [55:0]           rad_d  [SqrtStages];
  logic [29:0]           rem_d  [SqrtStages];
  logic [27:0]           root_d [SqrtStages];

  // Restoring square root: bring down two radicand bits, try (root << 2) | 1.
  always_comb begin
    logic [55:0] rad;
    logic [29:0] rem;
    logic [27:0] root;
    logic [31:0] rem_x;
    logic [31:0] trial;
    for (int g = 0; g < SqrtStages; g++) begin
      if (g == 0) begin
        rad  = radicand_i;
        rem  = '0;
        root = '0;
      end else begin
        rad  = rad_q[g-1];
        rem  = rem_q[g-1];
        root = root_q[g-1];
      end
      for (int k = 0; k < SqrtStepsPerStage; k++) begin
        rem_x = {rem, rad[55:54]};
        trial = {2'b00, root, 2'b01};
        rad   = {rad[53:0], 2'b00};
        if (rem_x >= trial) begin
          rem  = 30'(rem_x - trial);
          root = {root[26:0], 1'b1};
        end else begin
          rem  = rem_x[29:0];
          root = {root[26:0], 1'b0};
        end
      end
      rad_d[g]  = rad;
      rem_d[g]  = rem;
      root_d[g] = root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SqrtStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < SqrtStages; g++) begin
      rad_q[g]  <= rad_d[g];
      rem_q[g]  <= rem_d[g];
      root_q[g] <= root_d[g];
      side_q[g] <= (g == 0) ? side_i : side_q[(g == 0) ? 0 : g-1];
    end
  end

  assign valid_o = valid_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];
  assign side_o  = side_q[SqrtStages-1];

endmodule

`default_nettype wire

FILE: src/hcf_checker.sv
// Port-level checks of the contact force core, bound to its top level.
// Depends on hcf_pkg for the pipeline latency and the item types.
`timescale 1ns / 1ps
`default_nettype none

module hcf_checker import hcf_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input hcf_in_t  item_i,
  input logic     done_o,
  input hcf_out_t result_o
);

  localparam int unsigned AgeW = $clog2(HcfLatency + 1);

  logic [AgeW-1:0] age_q;
  logic            warm;

  // Count cycles since reset so that history reaches back no further than reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (age_q != AgeW'(HcfLatency)) begin
      age_q <= age_q + AgeW'(1);
    end
  end

  assign warm = (age_q == AgeW'(HcfLatency));

  // Every item gives exactly one result, a fixed latency later.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (done_o == $past(start && !busy, HcfLatency)))
    else $error("result strobe does not match item accepted at fixed latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o) |->
      (result_o.apply_to_second == $past(item_i.has_second_body, HcfLatency)))
    else $error("second-body flag does not follow its item");

  // No overlap or no stiffness, and no damping: no force at all.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o && $past(item_i.damping == 32'd0 &&
      (item_i.stiffness == 48'd0 || !item_i.separation[31]), HcfLatency)) |->
      (result_o.force_x == 48'sd0 && result_o.force_y == 48'sd0 &&
       result_o.force_z == 48'sd0 && result_o.normal_magnitude == 47'd0))
    else $error("nonzero force without spring or damping");

  // A zero normal has no normal component.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o && $past(item_i.normal_x == 32'sd0 && item_i.normal_y == 32'sd0 &&
      item_i.normal_z == 32'sd0, HcfLatency)) |->
      (result_o.normal_magnitude == 47'd0))
    else $error("nonzero normal magnitude for a zero normal");

endmodule

bind hertz_contact_force_core hcf_checker u_hcf_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench of hertz_contact_force_core: a table of directed contacts, then random ones,
// each result checked field by field against its stored expectation or a bit-exact force predictor.
// Depends on hcf_pkg and the core RTL only.

module tb_top;
  import hcf_pkg::*;

  // Wide enough for normal * spring (about 2^115) and every partial sum after it.
  typedef logic signed [167:0] wide_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct {
    hcf_in_t  contact;
    bit       typed;
    hcf_out_t want;
  } contact_row_t;

  localparam int unsigned RandomContacts = 750;
  localparam int unsigned StallLimit     = 2000;

  localparam logic [31:0] WordMin      = 32'h8000_0000;
  localparam logic [31:0] WordMax      = 32'h7FFF_FFFF;
  localparam logic [31:0] LengthOne    = 32'h0100_0000;  // 1.0 in Q8.24
  localparam logic [31:0] UnitNormal   = 32'h4000_0000;  // +1.0 in Q2.30
  localparam logic [31:0] NegUnitNormal = 32'hC000_0000; // -1.0 in Q2.30
  localparam logic [31:0] DiagNormal   = 32'h24F3_4E8B;  // 1/sqrt(3) in Q2.30
  localparam logic [47:0] StiffMax     = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] DampMax      = 32'hFFFF_FFFF;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  hcf_in_t  contact;
  logic     done_o;
  hcf_out_t result_o;

  hcf_out_t     pending_forces[$];   // expected results, oldest first
  contact_row_t directed_rows[$];
  hcf_out_t     oldest;
  bit           no_idle = 1'b0;
  int unsigned  mismatch_count = 0;
  int unsigned  stall_cycles = 0;

  hertz_contact_force_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (contact),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 12 ns period, low half first.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Predict the result of one contact with exact wide arithmetic.
  function automatic hcf_out_t hertz_force(input hcf_in_t c);
    logic signed [63:0] sep;
    logic [63:0]        overlap, rem, root, bitv, pow15;
    wide_t              spring, pw, damp, total, dot;
    wide_t              nrm [3];
    wide_t              vel [3];
    wide_t              frc [3];
    logic [47:0]        sat [3];
    hcf_out_t           r;
    sep     = $signed(c.separation);
    overlap = (sep < 0) ? -sep : 64'd0;
    // Integer square root of overlap * 2^24, i.e. sqrt(overlap) in Q4.24.
    rem  = overlap << 24;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    pow15  = (overlap * root) >> 24;
    spring = c.stiffness;
    pw     = pow15;
    spring = spring * pw;
    damp   = c.damping;
    nrm[0] = $signed(c.normal_x);
    nrm[1] = $signed(c.normal_y);
    nrm[2] = $signed(c.normal_z);
    vel[0] = $signed(c.rel_vel_x);
    vel[1] = $signed(c.rel_vel_y);
    vel[2] = $signed(c.rel_vel_z);
    for (int i = 0; i < 3; i++) begin
      total = nrm[i] * spring + ((damp * vel[i]) <<< 30);
      total = (-total) >>> 46;
      if (total > $signed(ForceMax)) begin
        sat[i] = ForceMax;
      end else if (total < $signed(ForceMin)) begin
        sat[i] = ForceMin;
      end else begin
        sat[i] = total[47:0];
      end
      frc[i] = $signed(sat[i]);
    end
    // The normal component uses the saturated forces.
    dot = nrm[0] * frc[0] + nrm[1] * frc[1] + nrm[2] * frc[2];
    if (dot < 0) dot = -dot;
    dot = dot >>> 30;
    r.force_x          = sat[0];
    r.force_y          = sat[1];
    r.force_z          = sat[2];
    r.normal_magnitude = (dot > wide_t'(MagMax)) ? MagMax : dot[46:0];
    r.apply_to_second  = c.has_second_body;
    return r;
  endfunction

  function automatic hcf_in_t mk_contact(
    input logic [31:0] sep,
    input logic [31:0] nx, input logic [31:0] ny, input logic [31:0] nz,
    input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
    input logic [47:0] stiff, input logic [31:0] damp, input logic second
  );
    hcf_in_t c;
    c.separation       = sep;
    c.normal_x         = nx;
    c.normal_y         = ny;
    c.normal_z         = nz;
    c.rel_vel_x        = vx;
    c.rel_vel_y        = vy;
    c.rel_vel_z        = vz;
    c.stiffness        = stiff;
    c.damping          = damp;
    c.has_second_body  = second;
    return c;
  endfunction

  // Random word of random magnitude: shifting keeps the sign, so small values,
  // -1 and 0 show up as often as full-width ones.
  function automatic logic [31:0] scaled_word();
    logic [31:0] w;
    w = $urandom();
    return $signed(w) >>> $urandom_range(0, 31);
  endfunction

  // Mostly overlapping contacts of log-spread depth; the rest open, touching or extreme.
  function automatic hcf_in_t random_contact();
    int unsigned mode;
    logic [31:0] sep, nx, ny, nz, axis_val;
    logic [63:0] s64;
    mode = $urandom_range(0, 19);
    if (mode < 12) begin
      sep = -($urandom() >> $urandom_range(1, 31));
    end else if (mode < 15) begin
      sep = $urandom() >> $urandom_range(1, 31);
    end else if (mode == 15) begin
      sep = '0;
    end else if (mode < 18) begin
      sep = $urandom();
    end else if (mode == 18) begin
      sep = WordMin;
    end else begin
      sep = WordMax;
    end
    if ($urandom_range(0, 3) == 0) begin
      // Axis-aligned unit normal, either direction.
      nx = '0;
      ny = '0;
      nz = '0;
      axis_val = $urandom_range(0, 1) ? UnitNormal : NegUnitNormal;
      case ($urandom_range(0, 2))
        0: nx = axis_val;
        1: ny = axis_val;
        default: nz = axis_val;
      endcase
    end else begin
      nx = scaled_word();
      ny = scaled_word();
      nz = scaled_word();
    end
    s64 = {$urandom(), $urandom()};
    return mk_contact(sep, nx, ny, nz, scaled_word(), scaled_word(), scaled_word(),
                      s64[47:0] >> $urandom_range(0, 47),
                      $urandom() >> $urandom_range(0, 31), 1'($urandom_range(0, 1)));
  endfunction

  task automatic report_mismatch(input string field, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", field, got, want, $time);
    mismatch_count++;
  endtask

  // Offer one contact after a random idle gap (none while no_idle is set), hold it until taken, then queue its result.
  // Drive at the falling edge so the core samples stable inputs.
  task automatic send_contact(input hcf_in_t c, input bit typed, input hcf_out_t want);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start   = 1'b1;
    contact = c;
    // busy read here is the value the core saw at this edge.
    do @(posedge clk_i); while (busy);
    pending_forces.push_back(typed ? want : hertz_force(c));
  endtask

  // Compare every result with the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_forces.size() == 0) begin
        report_mismatch("result with no contact pending", result_o.force_x, '0);
      end else begin
        oldest = pending_forces.pop_front();
        if (result_o.force_x !== oldest.force_x)
          report_mismatch("force_x", result_o.force_x, oldest.force_x);
        if (result_o.force_y !== oldest.force_y)
          report_mismatch("force_y", result_o.force_y, oldest.force_y);
        if (result_o.force_z !== oldest.force_z)
          report_mismatch("force_z", result_o.force_z, oldest.force_z);
        if (result_o.normal_magnitude !== oldest.normal_magnitude)
          report_mismatch("normal_magnitude", 48'(result_o.normal_magnitude),
                          48'(oldest.normal_magnitude));
        if (result_o.apply_to_second !== oldest.apply_to_second)
          report_mismatch("apply_to_second", 48'(result_o.apply_to_second),
                          48'(oldest.apply_to_second));
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    contact = '0;

    // Directed table: typed rows are zero or fully saturated results.
    directed_rows.push_back(contact_row_t'{mk_contact('0, '0, '0, '0, '0, '0, '0, '0, '0,
      1'b0), 1'b1, hcf_out_t'('0)});
    // Open contact: no spring force even at full stiffness; flag passes through.
    directed_rows.push_back(contact_row_t'{mk_contact(WordMax, UnitNormal, '0, '0,
      '0, '0, '0, StiffMax, '0, 1'b1), 1'b1,
      hcf_out_t'{48'd0, 48'd0, 48'd0, 47'd0, 1'b1}});
    // Touching contact: zero overlap, zero spring force.
    directed_rows.push_back(contact_row_t'{mk_contact('0, UnitNormal, UnitNormal,
      UnitNormal, '0, '0, '0, StiffMax, '0, 1'b0), 1'b1, hcf_out_t'('0)});
    // Deepest overlap, stiffest spring: force and magnitude saturate.
    directed_rows.push_back(contact_row_t'{mk_contact(WordMin, WordMax, '0, '0,
      '0, '0, '0, StiffMax, '0, 1'b0), 1'b1,
      hcf_out_t'{ForceMin, 48'd0, 48'd0, MagMax, 1'b0}});
    directed_rows.push_back(contact_row_t'{mk_contact(WordMin, '0, WordMin, '0,
      '0, '0, '0, StiffMax, '0, 1'b0), 1'b1,
      hcf_out_t'{48'd0, ForceMax, 48'd0, MagMax, 1'b0}});
    // Predicted rows from here on.
    directed_rows.push_back(contact_row_t'{mk_contact(-LengthOne, UnitNormal, '0, '0,
      '0, '0, '0, 48'h1_0000, '0, 1'b0), 1'b0, hcf_out_t'('0)});
    directed_rows.push_back(contact_row_t'{mk_contact(-LengthOne, '0, '0, NegUnitNormal,
      LengthOne, -LengthOne, 32'h0200_0000, 48'h64_0000, 32'h8000, 1'b1), 1'b0,
      hcf_out_t'('0)});
    // Smallest possible overlap.
    directed_rows.push_back(contact_row_t'{mk_contact(32'hFFFF_FFFF, '0, UnitNormal, '0,
      32'd1, 32'd1, 32'd1, StiffMax, DampMax, 1'b0), 1'b0, hcf_out_t'('0)});
    directed_rows.push_back(contact_row_t'{mk_contact(WordMin, UnitNormal, '0, '0,
      '0, '0, '0, 48'd1, '0, 1'b0), 1'b0, hcf_out_t'('0)});
    // Non-unit normal is used as given.
    directed_rows.push_back(contact_row_t'{mk_contact(-32'h0040_0000, WordMax, WordMax,
      WordMax, LengthOne, '0, -LengthOne, 48'h3E8_0000, 32'h1_0000, 1'b0), 1'b0,
      hcf_out_t'('0)});
    // Open contact, damping only, at the velocity extremes.
    directed_rows.push_back(contact_row_t'{mk_contact(WordMax, '0, '0, '0,
      WordMin, WordMin, WordMax, '0, DampMax, 1'b0), 1'b0, hcf_out_t'('0)});
    directed_rows.push_back(contact_row_t'{mk_contact(32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      StiffMax, DampMax, 1'b1), 1'b0, hcf_out_t'('0)});
    directed_rows.push_back(contact_row_t'{mk_contact(WordMin, WordMin, WordMin, WordMin,
      WordMax, WordMax, WordMax, StiffMax, DampMax, 1'b1), 1'b0, hcf_out_t'('0)});
    directed_rows.push_back(contact_row_t'{mk_contact(-32'h0200_0000, DiagNormal,
      DiagNormal, DiagNormal, -32'h0080_0000, 32'h0040_0000, -32'h0020_0000,
      48'h1388_0000, 32'h2_0000, 1'b0), 1'b0, hcf_out_t'('0)});
    directed_rows.push_back(contact_row_t'{mk_contact(-32'h0000_1000, UnitNormal,
      NegUnitNormal, '0, WordMax, WordMax, '0, 48'h10_0000, 32'h1_0000, 1'b1), 1'b0,
      hcf_out_t'('0)});
    directed_rows.push_back(contact_row_t'{mk_contact(32'd1, '0, '0, UnitNormal,
      '0, '0, -LengthOne, StiffMax, 32'hA_0000, 1'b0), 1'b0, hcf_out_t'('0)});
    directed_rows.push_back(contact_row_t'{mk_contact(-LengthOne, NegUnitNormal, '0, '0,
      WordMin, '0, '0, StiffMax, DampMax, 1'b1), 1'b0, hcf_out_t'('0)});

    // Hold reset, then release it away from the clock edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k])
      send_contact(directed_rows[k].contact, directed_rows[k].typed, directed_rows[k].want);

    // Random part: every 40 contacts, decide whether the next stretch runs back to back.
    for (int n = 0; n < RandomContacts; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_contact(random_contact(), 1'b0, hcf_out_t'('0));
    end
    @(negedge clk_i);
    start = 1'b0;

    // Drain: wait for every result, then let the pipeline run empty.
    while (pending_forces.size() != 0) @(posedge clk_i);
    repeat (HcfLatency + 4) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
